FILE: rtl/assert_macros.svh
// assertion macros used by the table datapath rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define RCIDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define RCIDT_ASSERT_NEVER(lbl, expr, msg) \
  `RCIDT_ASSERT(lbl, !(expr), msg)

`endif

FILE: rtl/rcidt_pkg.sv
// shared types and constants of the reference counted id table
package rcidt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned COUNT_WIDTH_DEF   = 16;
  localparam int unsigned ID_HALF_W         = 64;
  localparam int unsigned REF_COUNT_W       = 16;

  typedef enum logic [1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_UNREGISTER = 2'd1,
    MODE_QUERY      = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    mode_e                 mode;
    logic [ID_HALF_W-1:0]  id_high;
    logic [ID_HALF_W-1:0]  id_low;
  } cmd_t;

  typedef struct packed {
    status_e                status;
    logic                   unused;
    logic [REF_COUNT_W-1:0] ref_count;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic addr_clr;
    logic addr_inc;
    logic scan_rd;
    logic sweep_wr;
    logic finish;
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic addr_last;
    logic in_clear;
    logic in_zero;
  } stat_t;

endpackage

FILE: rtl/rcidt_ram.sv
// generic single write, single read ram with registered read data
module rcidt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rcidt_ctrl.sv
// controller state machine of the id table
module rcidt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rcidt_pkg::stat_t stat_i,
  output rcidt_pkg::ctrl_t ctrl_o
);

  rcidt_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcidt_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcidt_pkg::S_INIT: begin
        if (stat_i.addr_last) state_d = rcidt_pkg::S_IDLE;
      end
      rcidt_pkg::S_IDLE: begin
        if (start) begin
          if (stat_i.in_clear)     state_d = rcidt_pkg::S_CLEAR;
          else if (stat_i.in_zero) state_d = rcidt_pkg::S_FINISH;
          else                     state_d = rcidt_pkg::S_SCAN;
        end
      end
      rcidt_pkg::S_SCAN: begin
        if (stat_i.addr_last) state_d = rcidt_pkg::S_WAIT;
      end
      rcidt_pkg::S_WAIT:   state_d = rcidt_pkg::S_FINISH;
      rcidt_pkg::S_CLEAR: begin
        if (stat_i.addr_last) state_d = rcidt_pkg::S_FINISH;
      end
      rcidt_pkg::S_FINISH: state_d = rcidt_pkg::S_IDLE;
      default:             state_d = rcidt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    case (state_q)
      rcidt_pkg::S_INIT: begin
        ctrl_o.sweep_wr = 1'b1;
        ctrl_o.addr_inc = 1'b1;
        ctrl_o.addr_clr = stat_i.addr_last;
      end
      rcidt_pkg::S_IDLE: begin
        busy            = 1'b0;
        ctrl_o.load     = start;
        ctrl_o.addr_clr = start;
      end
      rcidt_pkg::S_SCAN: begin
        ctrl_o.scan_rd  = 1'b1;
        ctrl_o.addr_inc = 1'b1;
      end
      rcidt_pkg::S_WAIT: begin
        ctrl_o.addr_clr = 1'b1;
      end
      rcidt_pkg::S_CLEAR: begin
        ctrl_o.sweep_wr = 1'b1;
        ctrl_o.addr_inc = 1'b1;
      end
      rcidt_pkg::S_FINISH: begin
        ctrl_o.finish   = 1'b1;
        ctrl_o.addr_clr = 1'b1;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/rcidt_dpath.sv
// datapath of the id table: entry ram, scan registers and result logic
`include "assert_macros.svh"

module rcidt_dpath #(
  parameter int unsigned TABLE_ENTRIES = rcidt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_WIDTH   = rcidt_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcidt_pkg::cmd_t  cmd_i,
  input  rcidt_pkg::ctrl_t ctrl_i,
  output rcidt_pkg::stat_t stat_o,
  output logic             res_valid_o,
  output rcidt_pkg::res_t  res_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned HW      = rcidt_pkg::ID_HALF_W;
  localparam int unsigned ENTRY_W = 1 + 2 * HW + COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  rcidt_pkg::cmd_t          cmd_q;
  logic [IDX_W-1:0]         addr_q;
  logic                     rd_pend_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     match_found_q;
  logic [IDX_W-1:0]         match_idx_q;
  logic [COUNT_WIDTH-1:0]   match_refs_q;
  logic                     free_found_q;
  logic [IDX_W-1:0]         free_idx_q;
  logic                     res_valid_q;
  rcidt_pkg::res_t          res_q, res_d;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic                     rd_valid;
  logic [HW-1:0]            rd_hi;
  logic [HW-1:0]            rd_lo;
  logic [COUNT_WIDTH-1:0]   rd_refs;
  logic                     rd_hit;
  logic                     rd_free;
  logic                     cmd_zero;
  logic [COUNT_WIDTH-1:0]   cnt;
  logic [31:0]              cnt_ext;

  // entry storage
  rcidt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // status for the controller
  assign stat_o.addr_last = (addr_q == IDX_W'(TABLE_ENTRIES - 1));
  assign stat_o.in_clear  = (cmd_i.mode == rcidt_pkg::MODE_CLEAR);
  assign stat_o.in_zero   = (cmd_i.id_high == '0) && (cmd_i.id_low == '0);

  // read entry fields
  assign rd_valid = ram_rdata[ENTRY_W-1];
  assign rd_hi    = ram_rdata[COUNT_WIDTH+HW +: HW];
  assign rd_lo    = ram_rdata[COUNT_WIDTH +: HW];
  assign rd_refs  = ram_rdata[COUNT_WIDTH-1:0];
  assign rd_hit   = rd_pend_q && rd_valid &&
                    (rd_hi == cmd_q.id_high) && (rd_lo == cmd_q.id_low);
  assign rd_free  = rd_pend_q && !rd_valid;
  assign cmd_zero = (cmd_q.id_high == '0) && (cmd_q.id_low == '0);

  // command register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
    end
  end

  // scan address and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_pend_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (ctrl_i.addr_clr)      addr_q <= '0;
      else if (ctrl_i.addr_inc) addr_q <= addr_q + IDX_W'(1);
      rd_pend_q <= ctrl_i.scan_rd;
      rd_idx_q  <= addr_q;
    end
  end

  // match and first free slot capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else if (ctrl_i.load) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else begin
      if (rd_hit)                  match_found_q <= 1'b1;
      if (rd_free && !free_found_q) free_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_hit) begin
      match_idx_q  <= rd_idx_q;
      match_refs_q <= rd_refs;
    end
    if (rd_free && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // sweep writes, result and table update
  always_comb begin
    ram_we           = 1'b0;
    ram_waddr        = addr_q;
    ram_wdata        = '0;
    cnt              = '0;
    res_d.status     = rcidt_pkg::ST_OK;
    res_d.unused     = 1'b0;
    if (ctrl_i.sweep_wr) begin
      ram_we = 1'b1;
    end
    if (ctrl_i.finish && (cmd_q.mode != rcidt_pkg::MODE_CLEAR)) begin
      if (cmd_zero) begin
        res_d.status = rcidt_pkg::ST_INVALID;
      end else begin
        res_d.unused = !match_found_q;
        case (cmd_q.mode)
          rcidt_pkg::MODE_REGISTER: begin
            if (match_found_q) begin
              ram_waddr = match_idx_q;
              if (match_refs_q == CNT_MAX) begin
                res_d.status = rcidt_pkg::ST_SATURATED;
                cnt          = match_refs_q;
              end else begin
                cnt       = match_refs_q + CNT_ONE;
                ram_we    = 1'b1;
                ram_wdata = {1'b1, cmd_q.id_high, cmd_q.id_low, cnt};
              end
            end else if (free_found_q) begin
              ram_waddr = free_idx_q;
              cnt       = CNT_ONE;
              ram_we    = 1'b1;
              ram_wdata = {1'b1, cmd_q.id_high, cmd_q.id_low, CNT_ONE};
            end else begin
              res_d.status = rcidt_pkg::ST_FULL;
            end
          end
          rcidt_pkg::MODE_UNREGISTER: begin
            ram_waddr = match_idx_q;
            if (!match_found_q) begin
              res_d.status = rcidt_pkg::ST_NOT_FOUND;
            end else if (match_refs_q <= CNT_ONE) begin
              ram_we    = 1'b1;
              ram_wdata = '0;
            end else begin
              cnt       = match_refs_q - CNT_ONE;
              ram_we    = 1'b1;
              ram_wdata = {1'b1, cmd_q.id_high, cmd_q.id_low, cnt};
            end
          end
          rcidt_pkg::MODE_QUERY: begin
            if (match_found_q) cnt = match_refs_q;
          end
          default: begin
            cnt = '0;
          end
        endcase
      end
    end
    cnt_ext         = 32'(cnt);
    res_d.ref_count = cnt_ext[rcidt_pkg::REF_COUNT_W-1:0];
  end

  // result register, one cycle strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `RCIDT_ASSERT(a_res_single_cycle, res_valid_q |=> !res_valid_q, "result strobe longer than one cycle")
  `RCIDT_ASSERT_NEVER(a_scan_no_write, ctrl_i.scan_rd && ram_we, "table written during scan")
  `RCIDT_ASSERT_NEVER(a_single_match, rd_hit && match_found_q, "identifier held in two slots")

endmodule

FILE: rtl/refcounted_id_table_core.sv
// top level of the reference counted id table
//
// Table of TABLE_ENTRIES 128-bit identifiers with reference counts. After reset
// the block runs a clearing pass over every entry with busy high. An item
// is taken when start is high and busy is low. Register, unregister and query
// scan the entry ram one entry per cycle with busy high, and the result of an
// item strobes on res_valid_o for one cycle right after busy goes low; a new
// item may be started in that same cycle. Clear-all sweeps the ram with busy
// high; an identifier of zero skips the scan and goes straight to the result.
// The receiver cannot stall: every result is shown for exactly one cycle and
// must be taken then.
module refcounted_id_table_core #(
  parameter int unsigned TABLE_ENTRIES = rcidt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned COUNT_WIDTH   = rcidt_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  rcidt_pkg::cmd_t cmd_i,
  output logic            res_valid_o,
  output rcidt_pkg::res_t res_o
);

  rcidt_pkg::ctrl_t ctrl;
  rcidt_pkg::stat_t stat;

  // sequencer
  rcidt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // table and result logic
  rcidt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
